// File: hdl/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum pixel colourizer package
// Shared types and fixed constants for the colourizer datapath and its
// register file.
// ----------------------------------------------------------------------------
package spc_pkg;

  // Input field widths.
  localparam int COLUMN_W = 8;
  localparam int LEVEL_W  = 8;
  localparam int ROW_W    = 7;
  localparam int COLOUR_W = 16;
  localparam int BIN_W    = 9;

  // Register file geometry.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // Column of the centre bin.
  localparam logic [COLUMN_W-1:0] CENTRE_COL = 8'd128;

  // Marker green used for passband blending and the centre highlight.
  localparam logic [7:0] MARK_R = 8'd14;
  localparam logic [7:0] MARK_G = 8'd158;
  localparam logic [7:0] MARK_B = 8'd53;

  // Divisor that scales a level byte onto the scope bar height.
  localparam int SCOPE_DIV = 318;

  // Width of row * SCOPE_DIV for the widest row value.
  localparam int ROW_PROD_W = 16;

  localparam logic [COLOUR_W-1:0] PIXEL_WHITE = 16'hffff;

  typedef enum logic [1:0] {
    REG_PASS_START = 2'd0,
    REG_PASS_STOP  = 2'd1,
    REG_USB_ON     = 2'd2,
    REG_LSB_ON     = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_WATERFALL = 1'b0,
    CMD_SCOPE     = 1'b1
  } pixel_cmd_e;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic signed [BIN_W-1:0] pass_start;
    logic signed [BIN_W-1:0] pass_stop;
    logic                    usb_on;
    logic                    lsb_on;
  } cfg_t;

  // Per-pixel colouring controls handed from the selector to the ramp.
  typedef struct packed {
    logic [7:0] value;
    logic       blend;
    logic       highlight;
    logic       white;
  } px_ctl_t;

endpackage

// File: hdl/spectrum_pixel_colourizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum pixel colourizer
// Turns spectrum levels into RGB565 pixels for waterfall and scope views.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock and never raises busy, so a
// request can be issued in every cycle. Each request gives exactly one
// pixel: the request is captured in an input register, coloured
// by combinational logic, and the result is held in an output register that
// drives pixel_colour_o for one cycle with done_o high. The receiver cannot
// hold results off, so it must take every pixel in the cycle it appears.
// Passband and sideband registers are read through the APB port and should
// only be written while no request is in flight.
// ----------------------------------------------------------------------------
module spectrum_pixel_colourizer #(
  parameter int BAR_ROWS = 100
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request channel.
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd_i,
  input  logic [spc_pkg::COLUMN_W-1:0]     column_i,
  input  logic [spc_pkg::LEVEL_W-1:0]      level_i,
  input  logic [spc_pkg::ROW_W-1:0]        scope_row_i,
  // Result channel.
  output logic                             done_o,
  output logic [spc_pkg::COLOUR_W-1:0]     pixel_colour_o,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [spc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [spc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [spc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import spc_pkg::*;

  logic                  accept;
  logic                  vld_q;
  logic                  cmd_q;
  logic [COLUMN_W-1:0]   column_q;
  logic [LEVEL_W-1:0]    level_q;
  logic [ROW_W-1:0]      row_q;
  cfg_t                  cfg;
  px_ctl_t               ctl;
  logic [COLOUR_W-1:0]   colour_d;
  logic                  done_q;
  logic [COLOUR_W-1:0]   colour_q;

  // Every stage moves forward each cycle, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  spc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register. Payload is only meaningful while vld_q is set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      column_q <= column_i;
      level_q  <= level_i;
      row_q    <= scope_row_i;
    end
  end

  // Pixel kind, bar position and passband membership pick the ramp input.
  spc_pixel_sel #(
    .BAR_ROWS (BAR_ROWS)
  ) u_pixel_sel (
    .cfg_i       (cfg),
    .cmd_i       (cmd_q),
    .column_i    (column_q),
    .level_i     (level_q),
    .scope_row_i (row_q),
    .ctl_o       (ctl)
  );

  // The ramp turns that choice into a packed RGB565 word.
  spc_colour u_colour (
    .ctl_i    (ctl),
    .colour_o (colour_d)
  );

  // Result register: one strobe per captured request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      colour_q <= colour_d;
    end
  end

  assign done_o         = done_q;
  assign pixel_colour_o = colour_q;

  // A request that is taken is coloured in the next cycle.
  a_accept_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> vld_q)
    else $error("accepted request did not reach the colouring stage");

  // Each coloured request gives exactly one strobe.
  a_stage_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |=> done_o)
    else $error("coloured request produced no result strobe");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q |=> !done_o)
    else $error("result strobe without a request");

  // The bar top marker must come out as plain white.
  a_top_is_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && ctl.white) |=> (done_o && (pixel_colour_o == PIXEL_WHITE)))
    else $error("bar top pixel is not white");

endmodule

// File: hdl/spc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum pixel colourizer register file
// APB-style slave holding the passband bounds and sideband enables.
// ----------------------------------------------------------------------------
module spc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [spc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [spc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [spc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output spc_pkg::cfg_t                    cfg_o
);
  import spc_pkg::*;

  cfg_t     cfg_q;
  cfg_reg_e sel_reg;
  logic     wr_en;

  assign sel_reg = cfg_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (sel_reg)
        REG_PASS_START: cfg_q.pass_start <= signed'(pwdata[BIN_W-1:0]);
        REG_PASS_STOP:  cfg_q.pass_stop  <= signed'(pwdata[BIN_W-1:0]);
        REG_USB_ON:     cfg_q.usb_on     <= pwdata[0];
        REG_LSB_ON:     cfg_q.lsb_on     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel_reg)
      REG_PASS_START: prdata = {{(APB_DATA_W-BIN_W){1'b0}}, cfg_q.pass_start};
      REG_PASS_STOP:  prdata = {{(APB_DATA_W-BIN_W){1'b0}}, cfg_q.pass_stop};
      REG_USB_ON:     prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.usb_on};
      REG_LSB_ON:     prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.lsb_on};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/spc_pixel_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum pixel colourizer selector
// Decides the ramp value, passband blend, centre highlight and white marker
// for one registered pixel request.
// ----------------------------------------------------------------------------
module spc_pixel_sel #(
  parameter int BAR_ROWS = 100
) (
  input  spc_pkg::cfg_t                    cfg_i,
  input  logic                             cmd_i,
  input  logic [spc_pkg::COLUMN_W-1:0]     column_i,
  input  logic [spc_pkg::LEVEL_W-1:0]      level_i,
  input  logic [spc_pkg::ROW_W-1:0]        scope_row_i,
  output spc_pkg::px_ctl_t                 ctl_o
);
  import spc_pkg::*;

  localparam int LVL_PROD_W = $clog2(BAR_ROWS * 255 + 1);
  localparam int CMP_W      = (LVL_PROD_W > ROW_PROD_W ? LVL_PROD_W : ROW_PROD_W) + 1;
  localparam int NUM_ROWS   = 2 ** ROW_W;

  logic signed [BIN_W-1:0] offs;
  logic signed [BIN_W-1:0] neg_offs;
  logic                    usb_hit;
  logic                    lsb_hit;
  logic                    pass;
  logic                    centre;
  logic [CMP_W-1:0]        lvl_prod;
  logic [CMP_W-1:0]        row_lo;
  logic [CMP_W-1:0]        row_hi;
  logic                    row_below;
  logic                    row_on_top;
  logic [7:0]              idx_tab [NUM_ROWS];

  // Bin offset of the column from centre; -128..127, its negation fits too.
  assign offs     = signed'({1'b0, column_i}) - signed'({1'b0, CENTRE_COL});
  assign neg_offs = -offs;
  assign usb_hit  = (offs > cfg_i.pass_start) && (offs < cfg_i.pass_stop) && cfg_i.usb_on;
  assign lsb_hit  = (neg_offs > cfg_i.pass_start) && (neg_offs < cfg_i.pass_stop)
                    && cfg_i.lsb_on;
  assign pass     = usb_hit || lsb_hit;
  assign centre   = (column_i == CENTRE_COL);

  // The bar top is floor(H*level/318). Instead of dividing, the row is
  // bracketed: row < top exactly when (row+1)*318 <= H*level.
  assign lvl_prod   = CMP_W'(BAR_ROWS) * CMP_W'(level_i);
  assign row_lo     = CMP_W'(scope_row_i) * CMP_W'(SCOPE_DIV);
  assign row_hi     = row_lo + CMP_W'(SCOPE_DIV);
  assign row_below  = (row_hi <= lvl_prod);
  assign row_on_top = (row_lo <= lvl_prod) && !row_below;

  // Ramp index row*256/H for each possible row, saturated to a byte.
  for (genvar gi = 0; gi < NUM_ROWS; gi++) begin : g_idx
    localparam int IdxRaw = (gi * 256) / BAR_ROWS;
    localparam logic [7:0] IdxSat = (IdxRaw > 255) ? 8'hff : 8'(IdxRaw);
    assign idx_tab[gi] = IdxSat;
  end

  always_comb begin
    ctl_o.value     = level_i;
    ctl_o.blend     = pass;
    ctl_o.highlight = centre;
    ctl_o.white     = 1'b0;
    if (pixel_cmd_e'(cmd_i) == CMD_SCOPE) begin
      if (row_below) begin
        ctl_o.value     = idx_tab[scope_row_i];
        ctl_o.highlight = 1'b0;
      end else if (row_on_top) begin
        ctl_o.white = 1'b1;
      end else begin
        ctl_o.value = '0;
      end
    end
  end

endmodule

// File: hdl/spc_colour.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum pixel colourizer ramp
// Six-segment heat ramp with marker blending and RGB565 packing.
// ----------------------------------------------------------------------------
module spc_colour (
  input  spc_pkg::px_ctl_t                 ctl_i,
  output logic [spc_pkg::COLOUR_W-1:0]     colour_o
);
  import spc_pkg::*;

  logic [10:0] pos;
  logic [2:0]  seg;
  logic [7:0]  fr;
  logic [7:0]  r0, g0, b0;
  logic [7:0]  r1, g1, b1;
  logic [7:0]  r2, g2, b2;

  // value * 6 as two shifted adds.
  assign pos = {1'b0, ctl_i.value, 2'b00} + {2'b00, ctl_i.value, 1'b0};
  assign seg = pos[10:8];
  assign fr  = pos[7:0];

  always_comb begin
    r0 = '0;
    g0 = '0;
    b0 = '0;
    case (seg)
      3'd0: begin
        b0 = fr;
      end
      3'd1: begin
        g0 = fr;
        b0 = 8'hff;
      end
      3'd2: begin
        g0 = 8'hff;
        b0 = 8'hff - fr;
      end
      3'd3: begin
        r0 = fr;
        g0 = 8'hff;
      end
      3'd4: begin
        r0 = 8'hff;
        g0 = 8'hff - fr;
      end
      default: begin
        r0 = 8'hff;
        g0 = fr;
        b0 = fr;
      end
    endcase
  end

  // Half blend toward the marker; the sums stay below 256.
  always_comb begin
    if (ctl_i.blend) begin
      r1 = r0 - (r0 >> 1) + (MARK_R >> 1);
      g1 = g0 - (g0 >> 1) + (MARK_G >> 1);
      b1 = b0 - (b0 >> 1) + (MARK_B >> 1);
    end else begin
      r1 = r0;
      g1 = g0;
      b1 = b0;
    end
  end

  always_comb begin
    if (ctl_i.highlight) begin
      r2 = (r1 >> 2) + MARK_R - (MARK_R >> 2);
      g2 = (g1 >> 2) + MARK_G - (MARK_G >> 2);
      b2 = (b1 >> 2) + MARK_B - (MARK_B >> 2);
    end else begin
      r2 = r1;
      g2 = g1;
      b2 = b1;
    end
  end

  assign colour_o = ctl_i.white ? PIXEL_WHITE : {r2[7:3], g2[7:2], b2[7:3]};

endmodule

// File: test/spectrum_pixel_colourizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum pixel colourizer testbench
// Sends waterfall and scope pixel requests under several passband settings.
// Each returned pixel is checked against a hand-written colour or the predictor.
// ----------------------------------------------------------------------------
// The run has two parts. A short directed table covers the ends of the level
// ramp, the segment boundaries, the centre column and the scope bar edges.
// It runs under the reset register values. Six random phases follow. Each
// phase first programs the passband registers over APB and then sends about
// a hundred requests. Column and row values cluster around the passband
// edges and the bar top, so that the blend and compare logic is exercised
// hard. The sender idles 29 percent of the time in the first phases, then
// 65 percent, and then not at all. The result side has no back-pressure, so
// every done_o pulse is taken in the cycle it appears.
// ----------------------------------------------------------------------------
module spectrum_pixel_colourizer_tb;
  import spc_pkg::*;

  localparam int SCOPE_H         = 100;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 96;
  // Idle cycles allowed before the run is declared hung. This is far above
  // the longest gap of a correct run, which is set by register writes and
  // by the random sender pauses.
  localparam int STALL_LIMIT     = 2000;
  // Cycles allowed after the last pixel for a stray extra strobe to show.
  localparam int TAIL_CYCLES     = 6;

  // One row of the directed table. If known is set, colour is the pixel
  // written out by hand. Otherwise the predictor supplies the expected pixel.
  typedef struct packed {
    pixel_cmd_e            cmd;
    logic [COLUMN_W-1:0]   column;
    logic [LEVEL_W-1:0]    level;
    logic [ROW_W-1:0]      row;
    logic                  known;
    logic [COLOUR_W-1:0]   colour;
  } pixel_vec_t;

  typedef struct {
    int                  seq;
    logic [COLOUR_W-1:0] colour;
  } pending_pixel_t;

  localparam int NUM_DIRECTED = 24;
  localparam pixel_vec_t DIRECTED_VECS [NUM_DIRECTED] = '{
    // Waterfall ramp ends. The row bits are set but must be ignored.
    '{CMD_WATERFALL, 8'd0,    8'd0,   7'd0,   1'b1, 16'h0000},
    '{CMD_WATERFALL, 8'd255,  8'd255, 7'd127, 1'b1, 16'hffdf},
    // The centre column is highlighted toward the marker green.
    '{CMD_WATERFALL, 8'd128,  8'd0,   7'd0,   1'b0, 16'h0000},
    '{CMD_WATERFALL, 8'd128,  8'd255, 7'd0,   1'b0, 16'h0000},
    // Segment boundaries of the six-segment ramp.
    '{CMD_WATERFALL, 8'd1,    8'd42,  7'd0,   1'b0, 16'h0000},
    '{CMD_WATERFALL, 8'd2,    8'd43,  7'd0,   1'b0, 16'h0000},
    '{CMD_WATERFALL, 8'd64,   8'd85,  7'd0,   1'b0, 16'h0000},
    '{CMD_WATERFALL, 8'd127,  8'd86,  7'd0,   1'b0, 16'h0000},
    '{CMD_WATERFALL, 8'd129,  8'd128, 7'd0,   1'b0, 16'h0000},
    '{CMD_WATERFALL, 8'd170,  8'd170, 7'd0,   1'b0, 16'h0000},
    '{CMD_WATERFALL, 8'd200,  8'd171, 7'd0,   1'b0, 16'h0000},
    '{CMD_WATERFALL, 8'h55,   8'd213, 7'h55,  1'b0, 16'h0000},
    '{CMD_WATERFALL, 8'haa,   8'd214, 7'h2a,  1'b0, 16'h0000},
    // Scope bar. A row equal to the bar top is always white.
    '{CMD_SCOPE,     8'd0,    8'd0,   7'd0,   1'b1, 16'hffff},
    '{CMD_SCOPE,     8'd10,   8'd255, 7'd80,  1'b1, 16'hffff},
    '{CMD_SCOPE,     8'd10,   8'd255, 7'd79,  1'b0, 16'h0000},
    '{CMD_SCOPE,     8'd250,  8'd255, 7'd0,   1'b0, 16'h0000},
    // Background rows above a bar (black off centre) and white short-bar tops.
    '{CMD_SCOPE,     8'd0,    8'd0,   7'd127, 1'b1, 16'h0000},
    '{CMD_SCOPE,     8'd128,  8'd255, 7'd127, 1'b0, 16'h0000},
    '{CMD_SCOPE,     8'd128,  8'd3,   7'd0,   1'b1, 16'hffff},
    '{CMD_SCOPE,     8'd40,   8'd4,   7'd1,   1'b0, 16'h0000},
    // Background rows near the bar height, and one row inside the bar body.
    '{CMD_SCOPE,     8'd90,   8'd255, 7'd99,  1'b0, 16'h0000},
    '{CMD_SCOPE,     8'd91,   8'd255, 7'd100, 1'b0, 16'h0000},
    '{CMD_SCOPE,     8'd127,  8'd200, 7'd10,  1'b0, 16'h0000}
  };

  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  start          = 1'b0;
  logic                  busy;
  logic                  cmd_i          = 1'b0;
  logic [COLUMN_W-1:0]   column_i       = '0;
  logic [LEVEL_W-1:0]    level_i        = '0;
  logic [ROW_W-1:0]      scope_row_i    = '0;
  logic                  done_o;
  logic [COLOUR_W-1:0]   pixel_colour_o;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0] paddr          = '0;
  logic [APB_DATA_W-1:0] pwdata         = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Bench copy of the passband registers, updated on every APB write.
  cfg_t           band_cfg = '0;
  pending_pixel_t expected_pixels [$];
  int             mismatch_count = 0;
  int             pixels_sent    = 0;
  int             pixels_checked = 0;
  int             stall_cycles   = 0;

  spectrum_pixel_colourizer #(
    .BAR_ROWS(SCOPE_H)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .column_i      (column_i),
    .level_i       (level_i),
    .scope_row_i   (scope_row_i),
    .done_o        (done_o),
    .pixel_colour_o(pixel_colour_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Maps a ramp index onto the heat ramp. It then applies the optional half
  // blend and the three-quarter highlight toward the marker green, and packs
  // the result to RGB565.
  function automatic logic [COLOUR_W-1:0] ramp_rgb565(input logic [7:0] value,
                                                      input logic blend,
                                                      input logic highlight);
    int unsigned prod;
    int unsigned seg;
    int unsigned frac;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    prod = value * 6;
    seg  = prod >> 8;
    frac = prod & 8'hff;
    r = 0;
    g = 0;
    b = 0;
    case (seg)
      0: b = frac;
      1: begin
        g = frac;
        b = 255;
      end
      2: begin
        g = 255;
        b = 255 - frac;
      end
      3: begin
        r = frac;
        g = 255;
      end
      4: begin
        r = 255;
        g = 255 - frac;
      end
      default: begin
        r = 255;
        g = frac;
        b = frac;
      end
    endcase
    if (blend) begin
      r = r - (r >> 1) + (MARK_R >> 1);
      g = g - (g >> 1) + (MARK_G >> 1);
      b = b - (b >> 1) + (MARK_B >> 1);
    end
    if (highlight) begin
      r = (r >> 2) + MARK_R - (MARK_R >> 2);
      g = (g >> 2) + MARK_G - (MARK_G >> 2);
      b = (b >> 2) + MARK_B - (MARK_B >> 2);
    end
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // Expected pixel for one request under the current passband settings.
  function automatic logic [COLOUR_W-1:0] colourize_pixel(input pixel_cmd_e cmd,
                                                          input logic [7:0] column,
                                                          input logic [7:0] level,
                                                          input logic [6:0] row);
    int          offset;
    int          lo;
    int          hi;
    logic        in_pass;
    logic        centre;
    int unsigned top;
    int unsigned idx;
    offset  = int'(column) - int'(CENTRE_COL);
    lo      = $signed(band_cfg.pass_start);
    hi      = $signed(band_cfg.pass_stop);
    // The lower sideband mirrors the bin offset, so one window marks both sides.
    in_pass = (offset > lo && offset < hi && band_cfg.usb_on) ||
              (-offset > lo && -offset < hi && band_cfg.lsb_on);
    centre  = (column == CENTRE_COL);
    if (cmd == CMD_WATERFALL) begin
      return ramp_rgb565(level, in_pass, centre);
    end
    top = (SCOPE_H * level) / SCOPE_DIV;
    if (row < top) begin
      // Bar body: the colour follows the row height and is never highlighted.
      idx = (row * 256) / SCOPE_H;
      if (idx > 255) begin
        idx = 255;
      end
      return ramp_rgb565(idx[7:0], in_pass, 1'b0);
    end else if (row == top) begin
      return PIXEL_WHITE;
    end
    return ramp_rgb565(8'd0, in_pass, centre);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Full APB write: a setup cycle, then access cycles until pready. The bench
  // copy of the register is updated at the same point.
  task automatic write_reg(input cfg_reg_e idx, input logic signed [BIN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PASS_START: band_cfg.pass_start = value;
      REG_PASS_STOP:  band_cfg.pass_stop  = value;
      REG_USB_ON:     band_cfg.usb_on     = value[0];
      default:        band_cfg.lsb_on     = value[0];
    endcase
  endtask

  // Presents one request and holds it until a transaction takes place. busy
  // is read right after the edge, so it still shows the value that the
  // edge saw. The expected pixel is queued at that same edge.
  task automatic send_pixel(input pixel_cmd_e cmd, input logic [7:0] column,
                            input logic [7:0] level, input logic [6:0] row,
                            input logic known, input logic [COLOUR_W-1:0] colour);
    pending_pixel_t exp_px;
    start       <= 1'b1;
    cmd_i       <= cmd;
    column_i    <= column;
    level_i     <= level;
    scope_row_i <= row;
    do @(posedge clk_i); while (busy);
    exp_px.seq    = pixels_sent;
    exp_px.colour = known ? colour : colourize_pixel(cmd, column, level, row);
    expected_pixels.push_back(exp_px);
    pixels_sent++;
  endtask

  // Lowers start and then waits until every pixel in flight
  // has come back.
  task automatic drain_pixels();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Passband settings of each random phase. The first phases use the nominal
  // window extremes and single sidebands. Later ones use the full 9-bit
  // range, an inverted window that marks nothing, and random values.
  task automatic program_phase(input int phase);
    logic signed [BIN_W-1:0] lo;
    logic signed [BIN_W-1:0] hi;
    logic                    usb;
    logic                    lsb;
    case (phase)
      0: begin lo = -9'sd128; hi = 9'sd128; usb = 1'b1; lsb = 1'b1; end
      1: begin lo = 9'sd0;    hi = 9'sd20;  usb = 1'b1; lsb = 1'b0; end
      2: begin lo = 9'sd0;    hi = 9'sd20;  usb = 1'b0; lsb = 1'b1; end
      3: begin lo = -9'sd256; hi = 9'sd255; usb = 1'b1; lsb = 1'b1; end
      4: begin lo = 9'sd255;  hi = -9'sd256; usb = 1'b1; lsb = 1'b1; end
      default: begin
        lo  = BIN_W'($urandom_range(511));
        hi  = BIN_W'($urandom_range(511));
        usb = 1'($urandom_range(1));
        lsb = 1'($urandom_range(1));
      end
    endcase
    write_reg(REG_PASS_START, lo);
    write_reg(REG_PASS_STOP, hi);
    write_reg(REG_USB_ON, BIN_W'(usb));
    write_reg(REG_LSB_ON, BIN_W'(lsb));
  endtask

  // Result checker. done_o and the colour are sampled at the edge that ends
  // the strobe cycle.
  always @(posedge clk_i) begin
    pending_pixel_t exp_px;
    if (rst_ni && done_o) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel 0x%04h", pixel_colour_o));
      end else begin
        exp_px = expected_pixels.pop_front();
        pixels_checked++;
        if (pixel_colour_o !== exp_px.colour) begin
          report_mismatch($sformatf("pixel %0d: pixel_colour 0x%04h, expected 0x%04h",
                                    exp_px.seq, pixel_colour_o, exp_px.colour));
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d idle cycles", stall_cycles);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int               idle_pct;
    int               lo;
    int               hi;
    int               edge_bin;
    int               col;
    int               top;
    int               row;
    pixel_cmd_e       cmd_v;
    logic [7:0]       level_v;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset values of the passband registers.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_pixel(DIRECTED_VECS[i].cmd, DIRECTED_VECS[i].column, DIRECTED_VECS[i].level,
                 DIRECTED_VECS[i].row, DIRECTED_VECS[i].known, DIRECTED_VECS[i].colour);
    end

    // Random part. Registers are only written once no pixel is in flight.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pixels();
      program_phase(ph);
      idle_pct = (ph < 2) ? 29 : (ph < 4) ? 65 : 0;
      lo = $signed(band_cfg.pass_start);
      hi = $signed(band_cfg.pass_stop);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Halfway through, the sender pauses until the pipeline is empty.
        if (n == ITEMS_PER_PHASE / 2) begin
          drain_pixels();
        end
        while ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          @(posedge clk_i);
        end

        cmd_v = $urandom_range(1) ? CMD_SCOPE : CMD_WATERFALL;
        case ($urandom_range(9))
          0:       level_v = 8'd0;
          1:       level_v = 8'd255;
          default: level_v = 8'($urandom_range(255));
        endcase

        // About half the columns fall within a bin of a passband edge or the centre.
        // The rest are spread over the whole spectrum.
        col = $urandom_range(255);
        if ($urandom_range(9) < 5) begin
          case ($urandom_range(4))
            0:       edge_bin = lo;
            1:       edge_bin = hi;
            2:       edge_bin = -lo;
            3:       edge_bin = -hi;
            default: edge_bin = 0;
          endcase
          col = int'(CENTRE_COL) + edge_bin + int'($urandom_range(2)) - 1;
          if (col < 0 || col > 255) begin
            col = $urandom_range(255);
          end
        end

        // Scope rows mostly sit just around the bar top, where the
        // comparison flips between the ramp, white and the background.
        top = (SCOPE_H * level_v) / SCOPE_DIV;
        row = $urandom_range(127);
        if ($urandom_range(9) < 6) begin
          row = top + int'($urandom_range(2)) - 1;
          if (row < 0) begin
            row = 0;
          end
        end

        send_pixel(cmd_v, 8'(col), level_v, 7'(row), 1'b0, '0);
      end
    end

    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/spc_pkg.sv
hdl/spc_cfg_regs.sv
hdl/spc_pixel_sel.sv
hdl/spc_colour.sv
hdl/spectrum_pixel_colourizer.sv
test/spectrum_pixel_colourizer_tb.sv
